@@ rtl/core/jse_pkg.sv @@
// Shared types and constants for the Julia set escape-time engine.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package jse_pkg;

    // Fixed field widths of the channels and the configuration port
    localparam int DATA_W    = 32;
    localparam int PIXEL_W   = 10;
    localparam int OUT_W     = 8;
    localparam int CFG_IDX_W = 3;

    // Parameter defaults
    localparam int FRAC_BITS_DEF  = 28;
    localparam int COORD_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE_GAIN  = 3'd7;

    // Configuration reset values
    localparam logic signed [DATA_W-1:0] RST_CONST_REAL  = -32'sd26843546;
    localparam logic signed [DATA_W-1:0] RST_CONST_IMAG  = 32'sd214748365;
    localparam logic signed [DATA_W-1:0] RST_ORIGIN_REAL = -32'sd536870912;
    localparam logic signed [DATA_W-1:0] RST_ORIGIN_IMAG = 32'sd536870912;
    localparam logic signed [DATA_W-1:0] RST_STEP_REAL   = 32'sd1677722;
    localparam logic signed [DATA_W-1:0] RST_STEP_IMAG   = 32'sd2236962;
    localparam logic [OUT_W-1:0]         RST_MAX_ITER    = 8'd255;
    localparam logic [OUT_W-1:0]         RST_SHADE_GAIN  = 8'd6;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,  // capture pixel coordinates, clear count
        OP_MUL_X   = 4'd2,  // product x * step_real
        OP_START_R = 4'd3,  // set z real, product y * step_imag
        OP_START_I = 4'd4,  // set z imag
        OP_SQ_R    = 4'd5,  // product zr * zr
        OP_SQ_I    = 4'd6,  // product zi * zi
        OP_CROSS   = 4'd7,  // product zr * zi, magnitude test
        OP_STEP    = 4'd8,  // z = z*z + c, count up
        OP_EMIT    = 4'd9   // load result word
    } t_dp_op;

endpackage

@@ rtl/core/jse_pix_if.sv @@
// Pixel coordinate channel: valid/ready handshake with one coordinate pair.
// Depends on jse_pkg for the field width.
interface jse_pix_if;
    logic                         valid;
    logic                         ready;
    logic [jse_pkg::PIXEL_W-1:0]  pixel_x;
    logic [jse_pkg::PIXEL_W-1:0]  pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ rtl/core/jse_res_if.sv @@
// Result channel: valid/ready handshake with shade, count and escape flag.
// Depends on jse_pkg for the field widths.
interface jse_res_if;
    logic                       valid;
    logic                       ready;
    logic [jse_pkg::OUT_W-1:0]  shade;
    logic [jse_pkg::OUT_W-1:0]  iteration_count;
    logic                       escaped;

    modport source (output valid, output shade, output iteration_count, output escaped,
                    input ready);
    modport sink   (input valid, input shade, input iteration_count, input escaped,
                    output ready);
endinterface

@@ rtl/core/jse_ctrl.sv @@
// Sequencer for the escape-time engine: walks setup, iteration and result states.
// Depends on jse_pkg for the datapath command type.
module jse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  logic             i_stop,
    output jse_pkg::t_dp_op  o_op
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_MUL_X   = 9'b000000010,
        S_START_R = 9'b000000100,
        S_START_I = 9'b000001000,
        S_SQ_R    = 9'b000010000,
        S_SQ_I    = 9'b000100000,
        S_CROSS   = 9'b001000000,
        S_EVAL    = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and command
    always_comb begin
        n_state = r_state;
        o_op    = jse_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = jse_pkg::OP_LOAD;
                    n_state = S_MUL_X;
                end
            end
            S_MUL_X: begin
                o_op    = jse_pkg::OP_MUL_X;
                n_state = S_START_R;
            end
            S_START_R: begin
                o_op    = jse_pkg::OP_START_R;
                n_state = S_START_I;
            end
            S_START_I: begin
                o_op    = jse_pkg::OP_START_I;
                n_state = S_SQ_R;
            end
            S_SQ_R: begin
                o_op    = jse_pkg::OP_SQ_R;
                n_state = S_SQ_I;
            end
            S_SQ_I: begin
                o_op    = jse_pkg::OP_SQ_I;
                n_state = S_CROSS;
            end
            S_CROSS: begin
                o_op    = jse_pkg::OP_CROSS;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_stop) begin
                    n_state = S_DONE;
                end else begin
                    o_op    = jse_pkg::OP_STEP;
                    n_state = S_SQ_R;
                end
            end
            S_DONE: begin
                // hold until the output register can take the word
                if (w_out_free) begin
                    o_op    = jse_pkg::OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on emit, drop when the word is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_op == jse_pkg::OP_EMIT) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/core/jse_dp.sv @@
// Datapath of the escape-time engine: configuration registers, one shared
// 32x32 signed multiplier, z registers, counter and result word. Uses jse_pkg.
module jse_dp #(
    parameter int FRAC_BITS  = jse_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = jse_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [jse_pkg::DATA_W-1:0]        i_cfg_data,
    input  jse_pkg::t_dp_op                   i_op,
    input  logic [jse_pkg::PIXEL_W-1:0]       i_pixel_x,
    input  logic [jse_pkg::PIXEL_W-1:0]       i_pixel_y,
    output logic                              o_stop,
    output logic [jse_pkg::OUT_W-1:0]         o_shade,
    output logic [jse_pkg::OUT_W-1:0]         o_iteration_count,
    output logic                              o_escaped
);

    localparam int DW    = jse_pkg::DATA_W;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 2;
    localparam int LIM_W = (COUNT_BITS > jse_pkg::OUT_W) ? COUNT_BITS : jse_pkg::OUT_W;
    localparam int GP_W  = COUNT_BITS + jse_pkg::OUT_W;

    localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh000000007FFFFFFF);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sh0000000080000000);
    localparam logic [PW-1:0]        MAG_LIM = 64'd4 << (2 * FRAC_BITS);
    localparam logic [LIM_W-1:0]     CNT_MAX = LIM_W'((1 << COUNT_BITS) - 1);
    localparam logic [GP_W-1:0]      SHADE_MAX = GP_W'(255);

    // Clamp a wide signed value to the 32-bit range
    function automatic logic signed [DW-1:0] sat32(input logic signed [SW-1:0] v);
        logic signed [DW-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[DW-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[DW-1:0];
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

    // Configuration registers
    logic signed [DW-1:0]            r_const_real, r_const_imag;
    logic signed [DW-1:0]            r_origin_real, r_origin_imag;
    logic signed [DW-1:0]            r_step_real, r_step_imag;
    logic [jse_pkg::OUT_W-1:0]       r_max_iter, r_gain;

    // Working registers
    logic [COORD_BITS-1:0]           r_x, r_y;
    logic signed [DW-1:0]            r_zr, r_zi;
    logic signed [PW-1:0]            r_prod, r_rr, r_ii;
    logic                            r_outside;
    logic [COUNT_BITS-1:0]           r_count;
    logic [jse_pkg::OUT_W-1:0]       r_shade, r_iter_out;
    logic                            r_escaped;

    logic signed [DW-1:0]            w_mul_a, w_mul_b;
    logic signed [PW-1:0]            w_prod;
    logic signed [SW-1:0]            w_start_r, w_start_i, w_diff, w_re, w_im;
    logic [PW-1:0]                   w_mag;
    logic [LIM_W-1:0]                w_max_ext, w_lim_wide;
    logic [COUNT_BITS-1:0]           w_limit;
    logic                            w_below;
    logic [GP_W-1:0]                 w_gain_prod;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_real  <= jse_pkg::RST_CONST_REAL;
            r_const_imag  <= jse_pkg::RST_CONST_IMAG;
            r_origin_real <= jse_pkg::RST_ORIGIN_REAL;
            r_origin_imag <= jse_pkg::RST_ORIGIN_IMAG;
            r_step_real   <= jse_pkg::RST_STEP_REAL;
            r_step_imag   <= jse_pkg::RST_STEP_IMAG;
            r_max_iter    <= jse_pkg::RST_MAX_ITER;
            r_gain        <= jse_pkg::RST_SHADE_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jse_pkg::REG_CONST_REAL:  r_const_real  <= $signed(i_cfg_data);
                jse_pkg::REG_CONST_IMAG:  r_const_imag  <= $signed(i_cfg_data);
                jse_pkg::REG_ORIGIN_REAL: r_origin_real <= $signed(i_cfg_data);
                jse_pkg::REG_ORIGIN_IMAG: r_origin_imag <= $signed(i_cfg_data);
                jse_pkg::REG_STEP_REAL:   r_step_real   <= $signed(i_cfg_data);
                jse_pkg::REG_STEP_IMAG:   r_step_imag   <= $signed(i_cfg_data);
                jse_pkg::REG_MAX_ITER:    r_max_iter    <= i_cfg_data[jse_pkg::OUT_W-1:0];
                jse_pkg::REG_SHADE_GAIN:  r_gain        <= i_cfg_data[jse_pkg::OUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Select multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_op)
            jse_pkg::OP_MUL_X: begin
                w_mul_a = $signed(DW'(r_x));
                w_mul_b = r_step_real;
            end
            jse_pkg::OP_START_R: begin
                w_mul_a = $signed(DW'(r_y));
                w_mul_b = r_step_imag;
            end
            jse_pkg::OP_SQ_R: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            jse_pkg::OP_SQ_I: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            jse_pkg::OP_CROSS: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Start point, step and magnitude arithmetic
    assign w_start_r = SW'(r_origin_real) + SW'(r_prod);
    assign w_start_i = SW'(r_origin_imag) - SW'(r_prod);
    assign w_diff    = SW'(r_rr) - SW'(r_ii);
    assign w_re      = (w_diff >>> FRAC_BITS) + SW'(r_const_real);
    assign w_im      = (SW'(r_prod) >>> (FRAC_BITS - 1)) + SW'(r_const_imag);
    assign w_mag     = $unsigned(r_rr) + $unsigned(r_ii);

    // Limit clamped to the counter range
    assign w_max_ext  = LIM_W'(r_max_iter);
    assign w_lim_wide = (w_max_ext > CNT_MAX) ? CNT_MAX : w_max_ext;
    assign w_limit    = w_lim_wide[COUNT_BITS-1:0];
    assign w_below    = (r_count < w_limit);
    assign o_stop     = !w_below || r_outside;

    assign w_gain_prod = GP_W'(r_gain) * GP_W'(r_count);

    // Advance the working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end else begin
            unique case (i_op)
                jse_pkg::OP_LOAD: begin
                    r_x     <= COORD_BITS'(i_pixel_x);
                    r_y     <= COORD_BITS'(i_pixel_y);
                    r_count <= '0;
                end
                jse_pkg::OP_MUL_X: begin
                    r_prod <= w_prod;
                end
                jse_pkg::OP_START_R: begin
                    r_zr   <= sat32(w_start_r);
                    r_prod <= w_prod;
                end
                jse_pkg::OP_START_I: begin
                    r_zi <= sat32(w_start_i);
                end
                jse_pkg::OP_SQ_R: begin
                    r_rr <= w_prod;
                end
                jse_pkg::OP_SQ_I: begin
                    r_ii <= w_prod;
                end
                jse_pkg::OP_CROSS: begin
                    r_prod    <= w_prod;
                    r_outside <= (w_mag > MAG_LIM);
                end
                jse_pkg::OP_STEP: begin
                    r_zr    <= sat32(w_re);
                    r_zi    <= sat32(w_im);
                    r_count <= r_count + 1'b1;
                end
                jse_pkg::OP_EMIT: begin
                    r_escaped  <= w_below;
                    r_iter_out <= jse_pkg::OUT_W'(r_count);
                    if (!w_below) begin
                        r_shade <= '0;
                    end else if (w_gain_prod > SHADE_MAX) begin
                        r_shade <= '1;
                    end else begin
                        r_shade <= w_gain_prod[jse_pkg::OUT_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_shade           = r_shade;
    assign o_iteration_count = r_iter_out;
    assign o_escaped         = r_escaped;

endmodule

@@ rtl/core/julia_set_escape_time.sv @@
// Top level of the Julia set escape-time engine: controller plus datapath.
// Depends on jse_pkg, jse_pix_if, jse_res_if, jse_ctrl and jse_dp.
//
//   port       dir  word                                   handshake
//   i_pixel    in   pixel_x, pixel_y                       valid/ready
//   o_result   out  shade, iteration_count, escaped        valid/ready
//   i_cfg_*    in   index, 32-bit data                     write enable, no wait
//
// Each iteration feeds three products (zr*zr, zi*zi, zr*zi) through the single
// shared 32x32 multiplier and then updates z. One pixel is worked on at a time;
// the next is accepted as soon as the result word sits in the output register,
// even while that word is still stalled. Synchronous active-low reset restores the
// register defaults and leaves the engine idle.
module julia_set_escape_time #(
    parameter int FRAC_BITS  = jse_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = jse_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    jse_pix_if.sink                        i_pixel,
    jse_res_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [jse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jse_pkg::DATA_W-1:0]     i_cfg_data
);

    jse_pkg::t_dp_op w_op;
    logic            w_stop;

    jse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pixel.valid),
        .o_in_ready  (i_pixel.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .i_stop      (w_stop),
        .o_op        (w_op)
    );

    jse_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (w_op),
        .i_pixel_x         (i_pixel.pixel_x),
        .i_pixel_y         (i_pixel.pixel_y),
        .o_stop            (w_stop),
        .o_shade           (o_result.shade),
        .o_iteration_count (o_result.iteration_count),
        .o_escaped         (o_result.escaped)
    );

    // An emitted word shows up as valid in the next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == jse_pkg::OP_EMIT) |=> o_result.valid)
        else $error("emitted word not presented on the result channel");

    // A taken pixel makes the engine busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pixel.valid && i_pixel.ready) |=> !i_pixel.ready)
        else $error("pixel channel still ready right after a pixel was taken");

    // Points flagged as not escaped are dark
    a_inside_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.escaped) |-> (o_result.shade == '0))
        else $error("nonzero shade for a point that did not escape");

    // An escaped point stopped short of the limit, so its count stays below the counter top
    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.escaped) |-> (o_result.iteration_count != '1 ||
            COUNT_BITS > jse_pkg::OUT_W))
        else $error("escaped point reports the full counter range");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for julia_set_escape_time: sends pixel words, predicts the
// shade, count and escape flag of each one and checks every result word in order.
// Depends on jse_pkg, jse_pix_if, jse_res_if and the engine RTL.
module tb;

    localparam int     FRAC               = jse_pkg::FRAC_BITS_DEF;
    localparam int     IDLE_LIMIT         = 20000;
    localparam int     SETTLE_CYCLES      = 16;
    localparam int     WORDS_PER_SETTING  = 105;
    localparam int     SETTINGS_PER_PHASE = 6;
    localparam longint SAT_HI             = 64'sd2147483647;
    localparam longint SAT_LO             = -64'sd2147483648;

    // Register values after reset
    localparam logic [jse_pkg::DATA_W-1:0] DEF_C_RE   = -32'sd26843546;
    localparam logic [jse_pkg::DATA_W-1:0] DEF_C_IM   = 32'sd214748365;
    localparam logic [jse_pkg::DATA_W-1:0] DEF_ORG_RE = -32'sd536870912;
    localparam logic [jse_pkg::DATA_W-1:0] DEF_ORG_IM = 32'sd536870912;
    localparam logic [jse_pkg::DATA_W-1:0] DEF_STP_RE = 32'sd1677722;
    localparam logic [jse_pkg::DATA_W-1:0] DEF_STP_IM = 32'sd2236962;
    localparam logic [jse_pkg::OUT_W-1:0]  DEF_LIMIT  = 8'd255;
    localparam logic [jse_pkg::OUT_W-1:0]  DEF_GAIN   = 8'd6;

    // Grid for the saturation cases: origin (-2, +2), one sixteenth per pixel
    localparam logic [jse_pkg::DATA_W-1:0] SIXTEENTH  = 32'h0100_0000;

    typedef struct packed {
        logic [jse_pkg::OUT_W-1:0] shade;
        logic [jse_pkg::OUT_W-1:0] count;
        logic                      escaped;
    } t_escape_word;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [jse_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [jse_pkg::DATA_W-1:0]    i_cfg_data;

    jse_pix_if pix_if();
    jse_res_if res_if();

    julia_set_escape_time uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pixel     (pix_if),
        .o_result    (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the configuration
    longint      c_re, c_im, org_re, org_im, stp_re, stp_im;
    int unsigned iter_limit, gain;

    t_escape_word pending_escapes[$];
    int unsigned  mismatch_count = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_idle_pct  = 0;
    int unsigned  idle_cycles    = 0;

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Stall the result channel at random
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // |z|^2 <= 4, taken exactly with 2*FRAC fraction bits
    function automatic bit in_escape_disc(input longint zr, input longint zi);
        longint unsigned ar, ai;
        ar = (zr < 0) ? -zr : zr;
        ai = (zi < 0) ? -zi : zi;
        return (ar * ar + ai * ai) <= (64'd4 << (2 * FRAC));
    endfunction

    // Iterate z = z*z + c from the mapped pixel and build the result word
    function automatic t_escape_word predict_escape(
            input logic [jse_pkg::PIXEL_W-1:0] px,
            input logic [jse_pkg::PIXEL_W-1:0] py);
        longint       zr, zi, re, im;
        int unsigned  n;
        int unsigned  prod;
        t_escape_word w;
        zr = clamp32(org_re + longint'(px) * stp_re);
        zi = clamp32(org_im - longint'(py) * stp_im);
        n = 0;
        while (n < iter_limit && in_escape_disc(zr, zi)) begin
            re = (zr * zr - zi * zi) >>> FRAC;
            im = (zr * zi) >>> (FRAC - 1);
            zr = clamp32(re + c_re);
            zi = clamp32(im + c_im);
            n++;
        end
        w.count   = n[jse_pkg::OUT_W-1:0];
        w.escaped = (n < iter_limit);
        prod      = gain * n;
        if (!w.escaped) w.shade = '0;
        else if (prod > 255) w.shade = 8'd255;
        else w.shade = prod[jse_pkg::OUT_W-1:0];
        return w;
    endfunction

    // Write one register and mirror it in the predictor; call at a falling edge
    task automatic write_cfg(input logic [jse_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jse_pkg::DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        case (idx)
            jse_pkg::REG_CONST_REAL:  c_re   = longint'($signed(data));
            jse_pkg::REG_CONST_IMAG:  c_im   = longint'($signed(data));
            jse_pkg::REG_ORIGIN_REAL: org_re = longint'($signed(data));
            jse_pkg::REG_ORIGIN_IMAG: org_im = longint'($signed(data));
            jse_pkg::REG_STEP_REAL:   stp_re = longint'($signed(data));
            jse_pkg::REG_STEP_IMAG:   stp_im = longint'($signed(data));
            jse_pkg::REG_MAX_ITER:    iter_limit = 32'(data[jse_pkg::OUT_W-1:0]);
            jse_pkg::REG_SHADE_GAIN:  gain = 32'(data[jse_pkg::OUT_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic program_view(input logic [jse_pkg::DATA_W-1:0] cr,
                                input logic [jse_pkg::DATA_W-1:0] ci,
                                input logic [jse_pkg::DATA_W-1:0] ore,
                                input logic [jse_pkg::DATA_W-1:0] oim,
                                input logic [jse_pkg::DATA_W-1:0] sre,
                                input logic [jse_pkg::DATA_W-1:0] sim,
                                input logic [jse_pkg::OUT_W-1:0] lim,
                                input logic [jse_pkg::OUT_W-1:0] g);
        write_cfg(jse_pkg::REG_CONST_REAL, cr);
        write_cfg(jse_pkg::REG_CONST_IMAG, ci);
        write_cfg(jse_pkg::REG_ORIGIN_REAL, ore);
        write_cfg(jse_pkg::REG_ORIGIN_IMAG, oim);
        write_cfg(jse_pkg::REG_STEP_REAL, sre);
        write_cfg(jse_pkg::REG_STEP_IMAG, sim);
        write_cfg(jse_pkg::REG_MAX_ITER, {24'd0, lim});
        write_cfg(jse_pkg::REG_SHADE_GAIN, {24'd0, g});
    endtask

    // Offer one pixel word, hold it until taken, queue its prediction
    task automatic send_pixel(input logic [jse_pkg::PIXEL_W-1:0] px,
                              input logic [jse_pkg::PIXEL_W-1:0] py);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid   = 1'b1;
        pix_if.pixel_x = px;
        pix_if.pixel_y = py;
        do @(posedge i_clk); while (!pix_if.ready);
        pending_escapes.push_back(predict_escape(px, py));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result word has come back
    task automatic drain_results();
        pix_if.valid = 1'b0;
        while (pending_escapes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Reset view: corners, center and one point near the set
    task automatic test_default_view();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd320, 10'd240);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd300, 10'd250);
    endtask

    // Zero and unit limits, shade clamp and zero gain
    task automatic test_iteration_limits();
        drain_results();
        write_cfg(jse_pkg::REG_MAX_ITER, 32'd0);
        send_pixel(10'd320, 10'd240);
        send_pixel(10'd1023, 10'd1023);
        drain_results();
        write_cfg(jse_pkg::REG_MAX_ITER, 32'd1);
        send_pixel(10'd320, 10'd240);
        send_pixel(10'd0, 10'd0);
        drain_results();
        write_cfg(jse_pkg::REG_MAX_ITER, 32'd255);
        write_cfg(jse_pkg::REG_SHADE_GAIN, 32'd255);
        send_pixel(10'd330, 10'd240);
        send_pixel(10'd100, 10'd100);
        drain_results();
        write_cfg(jse_pkg::REG_SHADE_GAIN, 32'd0);
        send_pixel(10'd200, 10'd200);
        drain_results();
        write_cfg(jse_pkg::REG_SHADE_GAIN, {24'd0, DEF_GAIN});
    endtask

    // Clamp of the start point and of both parts of z*z + c, both directions
    task automatic test_saturation();
        drain_results();
        program_view(DEF_C_RE, DEF_C_IM, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, DEF_LIMIT, DEF_GAIN);
        send_pixel(10'd1023, 10'd1023);
        drain_results();
        program_view(DEF_C_RE, DEF_C_IM, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, DEF_LIMIT, DEF_GAIN);
        send_pixel(10'd1023, 10'd1023);
        drain_results();
        program_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, DEF_ORG_RE, DEF_ORG_IM,
                     SIXTEENTH, SIXTEENTH, DEF_LIMIT, DEF_GAIN);
        send_pixel(10'd54, 10'd10);
        send_pixel(10'd62, 10'd32);
        send_pixel(10'd32, 10'd2);
        send_pixel(10'd54, 10'd54);
        drain_results();
        program_view(32'h8000_0000, 32'h8000_0000, DEF_ORG_RE, DEF_ORG_IM,
                     SIXTEENTH, SIXTEENTH, DEF_LIMIT, DEF_GAIN);
        send_pixel(10'd54, 10'd10);
        send_pixel(10'd62, 10'd32);
        send_pixel(10'd32, 10'd2);
        send_pixel(10'd54, 10'd54);
        drain_results();
        program_view(DEF_C_RE, DEF_C_IM, DEF_ORG_RE, DEF_ORG_IM,
                     DEF_STP_RE, DEF_STP_IM, DEF_LIMIT, DEF_GAIN);
    endtask

    // Random views: mostly framed around the set with short limits, some raw noise
    task automatic test_random_views(input int unsigned sidle, input int unsigned ridle);
        bit                          framed;
        logic [jse_pkg::PIXEL_W-1:0] px, py;
        logic [jse_pkg::OUT_W-1:0]   lim, g;
        drain_results();
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        repeat (SETTINGS_PER_PHASE) begin
            drain_results();
            framed = ($urandom_range(0, 3) != 0);
            if (framed) begin
                lim = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(128, 255))
                                                  : 8'($urandom_range(1, 40));
                g = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 12))
                                                : 8'($urandom_range(0, 255));
                program_view($urandom_range(0, 32'h2000_0000) - 32'h1000_0000,
                             $urandom_range(0, 32'h2000_0000) - 32'h1000_0000,
                             DEF_ORG_RE + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
                             DEF_ORG_IM + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
                             $urandom_range(800000, 3400000),
                             $urandom_range(800000, 3400000), lim, g);
            end else begin
                program_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            repeat (WORDS_PER_SETTING) begin
                if (framed && $urandom_range(0, 4) != 0) begin
                    px = jse_pkg::PIXEL_W'($urandom_range(0, 639));
                    py = jse_pkg::PIXEL_W'($urandom_range(0, 479));
                end else begin
                    px = jse_pkg::PIXEL_W'($urandom_range(0, 1023));
                    py = jse_pkg::PIXEL_W'($urandom_range(0, 1023));
                end
                send_pixel(px, py);
            end
        end
    endtask

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_escape_word want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_escapes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("tb: unexpected result word: shade=%0d count=%0d escaped=%0b",
                             res_if.shade, res_if.iteration_count, res_if.escaped);
            end else begin
                want = pending_escapes.pop_front();
                if (res_if.shade !== want.shade || res_if.iteration_count !== want.count ||
                    res_if.escaped !== want.escaped) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tb: mismatch: shade %0d/%0d count %0d/%0d escaped %0b/%0b",
                                 want.shade, res_if.shade, want.count,
                                 res_if.iteration_count, want.escaped, res_if.escaped);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no word moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = jse_pkg::REG_CONST_REAL;
        i_cfg_data     = '0;
        pix_if.valid   = 1'b0;
        pix_if.pixel_x = '0;
        pix_if.pixel_y = '0;
        c_re       = longint'($signed(DEF_C_RE));
        c_im       = longint'($signed(DEF_C_IM));
        org_re     = longint'($signed(DEF_ORG_RE));
        org_im     = longint'($signed(DEF_ORG_IM));
        stp_re     = longint'($signed(DEF_STP_RE));
        stp_im     = longint'($signed(DEF_STP_IM));
        iter_limit = 32'(DEF_LIMIT);
        gain       = 32'(DEF_GAIN);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 49;
        test_default_view();
        test_iteration_limits();
        test_saturation();
        test_random_views(10, 49);
        test_random_views(49, 10);
        test_random_views(0, 0);
        drain_results();

        if (mismatch_count == 0 && pending_escapes.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
